// ===== rtl/modular_matrix_power_2x2_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the modular matrix power block
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MODULAR_MATRIX_POWER_2X2_ASSERT_SVH
`define MODULAR_MATRIX_POWER_2X2_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMP_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MMP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/mmp_pkg.sv =====
// ----------------------------------------------------------------------------
// mmp_pkg
// Types, constants and helper functions shared by the matrix power block.
// ----------------------------------------------------------------------------
package mmp_pkg;

    localparam int unsigned ENTRY_W     = 30;
    localparam int unsigned EXP_W       = 63;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned TAG_W       = 4;

    localparam logic [ENTRY_W-1:0] PRIME     = 30'd1000000007;
    localparam logic [31:0]        TWO_PRIME = 32'd2000000014;
    // floor(2^60 / PRIME), the Barrett reciprocal for 30-bit moduli.
    localparam logic [30:0]        BARRETT_MU = 31'd1152921496;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_TOP_LEFT     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_TOP_RIGHT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_BOTTOM_LEFT  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_BOTTOM_RIGHT = 2'd3;

    // Product tags: bit 3 picks the matrix product (accumulate or square),
    // bits 2:1 the result entry, bit 0 the term of the dot product.
    localparam logic [TAG_W-1:0] TAG_ACC_FIRST = 4'd0;
    localparam logic [TAG_W-1:0] TAG_ACC_LAST  = 4'd7;
    localparam logic [TAG_W-1:0] TAG_SQ_FIRST  = 4'd8;
    localparam logic [TAG_W-1:0] TAG_SQ_LAST   = 4'd15;

    typedef logic [ENTRY_W-1:0] entry_t;

    typedef struct packed {
        entry_t e00;
        entry_t e01;
        entry_t e10;
        entry_t e11;
    } mat_t;

    localparam mat_t IDENTITY = '{e00: 30'd1, e01: 30'd0, e10: 30'd0, e11: 30'd1};

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        entry_t           a;
        entry_t           b;
    } mmp_op_t;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        entry_t           value;
    } mmp_res_t;

    function automatic entry_t reduce_once(entry_t v);
        return (v >= PRIME) ? entry_t'(v - PRIME) : v;
    endfunction

    function automatic entry_t add_mod(entry_t a, entry_t b);
        logic [ENTRY_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, PRIME}) ? entry_t'(s - {1'b0, PRIME}) : entry_t'(s);
    endfunction

    function automatic entry_t mat_entry(mat_t m, logic [1:0] idx);
        entry_t v;
        unique case (idx)
            2'd0:    v = m.e00;
            2'd1:    v = m.e01;
            2'd2:    v = m.e10;
            default: v = m.e11;
        endcase
        return v;
    endfunction

    function automatic mat_t mat_set(mat_t m, logic [1:0] idx, entry_t v);
        mat_t r;
        r = m;
        unique case (idx)
            2'd0:    r.e00 = v;
            2'd1:    r.e01 = v;
            2'd2:    r.e10 = v;
            default: r.e11 = v;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/mmp_modmul.sv =====
// ----------------------------------------------------------------------------
// mmp_modmul
// Pipelined modular multiplier, one product a*b mod PRIME per cycle,
// Barrett reduction with two final corrections.
// ----------------------------------------------------------------------------
module mmp_modmul (
    input  logic              aclk,
    input  logic              aresetn,
    input  mmp_pkg::mmp_op_t  op_i,
    output mmp_pkg::mmp_res_t res_o
);

    logic                       s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [mmp_pkg::TAG_W-1:0]  s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg;
    logic [59:0]                s1_prod_reg;
    logic [61:0]                s2_qm_reg;
    logic [31:0]                s2_xlo_reg, s3_xlo_reg, s3_qp_reg;
    mmp_pkg::entry_t            s4_value_reg;

    logic [59:0]                prod_next;
    logic [61:0]                qm_next;
    logic [60:0]                qp_full;
    logic [31:0]                rem;
    mmp_pkg::entry_t            value_next;

    always_comb begin
        prod_next = 60'(op_i.a) * 60'(op_i.b);
        qm_next   = 62'(s1_prod_reg[59:29]) * 62'(mmp_pkg::BARRETT_MU);
        qp_full   = 61'(s2_qm_reg[61:31]) * 61'(mmp_pkg::PRIME);
        // The Barrett estimate is at most two short, so the remainder is below 3P.
        rem       = s3_xlo_reg - s3_qp_reg;
        if (rem >= mmp_pkg::TWO_PRIME) begin
            value_next = mmp_pkg::entry_t'(rem - mmp_pkg::TWO_PRIME);
        end else if (rem >= 32'(mmp_pkg::PRIME)) begin
            value_next = mmp_pkg::entry_t'(rem - 32'(mmp_pkg::PRIME));
        end else begin
            value_next = rem[mmp_pkg::ENTRY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= op_i.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_tag_reg   <= op_i.tag;
        s1_prod_reg  <= prod_next;
        s2_tag_reg   <= s1_tag_reg;
        s2_qm_reg    <= qm_next;
        s2_xlo_reg   <= s1_prod_reg[31:0];
        s3_tag_reg   <= s2_tag_reg;
        s3_qp_reg    <= qp_full[31:0];
        s3_xlo_reg   <= s2_xlo_reg;
        s4_tag_reg   <= s3_tag_reg;
        s4_value_reg <= value_next;
    end

    assign res_o.valid = s4_valid_reg;
    assign res_o.tag   = s4_tag_reg;
    assign res_o.value = s4_value_reg;

endmodule

// ===== rtl/modular_matrix_power_2x2.sv =====
// ----------------------------------------------------------------------------
// modular_matrix_power_2x2
// Raises a configurable 2x2 base matrix to a 63-bit power modulo 1000000007.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid, s_ready, s_exponent) takes one exponent word.
// The result channel (m_valid, m_ready, m_power_*) returns one word holding
// all four entries of base^exponent, each reduced modulo the prime.
// The configuration port writes the four base entries (index 0 top left to
// index 3 bottom right), reduced modulo the prime on use; write only while idle.
// Operation: square-and-multiply, least significant exponent bit first. Each
// exponent bit issues 8 or 16 products into one shared modular multiplier
// that takes one product per cycle, then drains it in ST_DRAIN and commits
// the bit in ST_COMMIT. A zero exponent goes straight to ST_FINISH; the
// product count sets the rate, and a new word is taken only once the block
// is back in ST_IDLE.
// s_ready is high only while the block is idle; it drops after an accept.
// A finished result waits in the output register; if the receiver stalls,
// the next item is still accepted and computed, and held until the
// output register is free. Reset restores the Fibonacci base [[1,1],[1,0]].
// ----------------------------------------------------------------------------
`include "modular_matrix_power_2x2_assert.svh"

module modular_matrix_power_2x2 (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [mmp_pkg::EXP_W-1:0]          s_exponent,
    // Result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mmp_pkg::ENTRY_W-1:0]        m_power_top_left,
    output logic [mmp_pkg::ENTRY_W-1:0]        m_power_top_right,
    output logic [mmp_pkg::ENTRY_W-1:0]        m_power_bottom_left,
    output logic [mmp_pkg::ENTRY_W-1:0]        m_power_bottom_right,
    // Configuration port
    input  logic                               cfg_wr_en,
    input  logic [mmp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mmp_pkg::ENTRY_W-1:0]        cfg_wr_data
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ISSUE  = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_COMMIT = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    logic [mmp_pkg::TAG_W-1:0]      tag_reg, tag_next;
    logic [mmp_pkg::EXP_W-1:0]      exp_reg, exp_next;
    mmp_pkg::mat_t                  acc_reg, acc_next;
    mmp_pkg::mat_t                  sq_reg, sq_next;
    mmp_pkg::mat_t                  acc_new_reg, acc_new_next;
    mmp_pkg::mat_t                  sq_new_reg, sq_new_next;
    mmp_pkg::entry_t                hold_reg, hold_next;
    mmp_pkg::mat_t                  base_reg, base_next;
    mmp_pkg::mat_t                  out_reg, out_next;
    logic                           m_valid_reg, m_valid_next;

    mmp_pkg::mmp_op_t               op;
    mmp_pkg::mmp_res_t              res;

    logic                           last_bit;
    logic [mmp_pkg::TAG_W-1:0]      issue_end;
    mmp_pkg::mat_t                  left_mat;
    mmp_pkg::mat_t                  base_red;
    mmp_pkg::entry_t                sum;

    logic                           mul_window;
    logic                           out_reduced;

    // The last exponent bit needs no further squaring, so only the
    // accumulate product is issued for it.
    assign last_bit  = (exp_reg[mmp_pkg::EXP_W-1:1] == '0);
    assign issue_end = last_bit ? mmp_pkg::TAG_ACC_LAST : mmp_pkg::TAG_SQ_LAST;

    // Operand selection: entry (i,j) of L*R takes L[i][m] * R[m][j] for
    // the term m given by the tag's low bit.
    always_comb begin
        left_mat = tag_reg[3] ? sq_reg : acc_reg;
        op.valid = (state_reg == ST_ISSUE);
        op.tag   = tag_reg;
        op.a     = mmp_pkg::mat_entry(left_mat, {tag_reg[2], tag_reg[0]});
        op.b     = mmp_pkg::mat_entry(sq_reg, {tag_reg[0], tag_reg[1]});
    end

    mmp_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_i    (op),
        .res_o   (res)
    );

    always_comb begin
        base_red.e00 = mmp_pkg::reduce_once(base_reg.e00);
        base_red.e01 = mmp_pkg::reduce_once(base_reg.e01);
        base_red.e10 = mmp_pkg::reduce_once(base_reg.e10);
        base_red.e11 = mmp_pkg::reduce_once(base_reg.e11);
        sum          = mmp_pkg::add_mod(hold_reg, res.value);
    end

    always_comb begin
        state_next   = state_reg;
        tag_next     = tag_reg;
        exp_next     = exp_reg;
        acc_next     = acc_reg;
        sq_next      = sq_reg;
        acc_new_next = acc_new_reg;
        sq_new_next  = sq_new_reg;
        hold_next    = hold_reg;
        base_next    = base_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (cfg_index)
                mmp_pkg::CFG_BASE_TOP_LEFT:     base_next.e00 = cfg_wr_data;
                mmp_pkg::CFG_BASE_TOP_RIGHT:    base_next.e01 = cfg_wr_data;
                mmp_pkg::CFG_BASE_BOTTOM_LEFT:  base_next.e10 = cfg_wr_data;
                mmp_pkg::CFG_BASE_BOTTOM_RIGHT: base_next.e11 = cfg_wr_data;
                default:                        base_next     = base_reg;
            endcase
        end

        // Products come back in issue order, so the two terms of one entry
        // arrive back to back: hold the first, add the second.
        if (res.valid) begin
            if (!res.tag[0]) begin
                hold_next = res.value;
            end else if (res.tag[3]) begin
                sq_new_next = mmp_pkg::mat_set(sq_new_reg, res.tag[2:1], sum);
            end else begin
                acc_new_next = mmp_pkg::mat_set(acc_new_reg, res.tag[2:1], sum);
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    exp_next = s_exponent;
                    acc_next = mmp_pkg::IDENTITY;
                    sq_next  = base_red;
                    tag_next = s_exponent[0] ? mmp_pkg::TAG_ACC_FIRST
                                             : mmp_pkg::TAG_SQ_FIRST;
                    state_next = (s_exponent == '0) ? ST_FINISH : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                tag_next = tag_reg + 1'b1;
                if (tag_reg == issue_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (res.valid && (res.tag == issue_end)) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (exp_reg[0]) begin
                    acc_next = acc_new_reg;
                end
                sq_next  = sq_new_reg;
                exp_next = exp_reg >> 1;
                tag_next = exp_reg[1] ? mmp_pkg::TAG_ACC_FIRST : mmp_pkg::TAG_SQ_FIRST;
                state_next = last_bit ? ST_FINISH : ST_ISSUE;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = acc_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            base_reg    <= '{e00: 30'd1, e01: 30'd1, e10: 30'd1, e11: 30'd0};
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            base_reg    <= base_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg     <= tag_next;
        exp_reg     <= exp_next;
        acc_reg     <= acc_next;
        sq_reg      <= sq_next;
        acc_new_reg <= acc_new_next;
        sq_new_reg  <= sq_new_next;
        hold_reg    <= hold_next;
        out_reg     <= out_next;
    end

    assign s_ready              = (state_reg == ST_IDLE);
    assign m_valid              = m_valid_reg;
    assign m_power_top_left     = out_reg.e00;
    assign m_power_top_right    = out_reg.e01;
    assign m_power_bottom_left  = out_reg.e10;
    assign m_power_bottom_right = out_reg.e11;

    assign mul_window  = (state_reg == ST_ISSUE) || (state_reg == ST_DRAIN);
    assign out_reduced = (out_reg.e00 < mmp_pkg::PRIME) && (out_reg.e01 < mmp_pkg::PRIME)
                      && (out_reg.e10 < mmp_pkg::PRIME) && (out_reg.e11 < mmp_pkg::PRIME);

    // Multiplier results only return while a bit is being worked on.
    `MMP_ASSERT_SAME(a_res_in_window, aclk, aresetn, res.valid, mul_window)
    // An accepted word takes the block out of idle.
    `MMP_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
    // Every delivered entry is fully reduced.
    `MMP_ASSERT_SAME(a_out_reduced, aclk, aresetn, m_valid, out_reduced)

endmodule
